// ----- design/order_crossover_permutation_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ORDER_CROSSOVER_PERMUTATION_MACROS_SVH
`define ORDER_CROSSOVER_PERMUTATION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OCX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order crossover check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OCX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order crossover check failed");

`endif

// ----- design/ocx_pkg.sv -----
package ocx_pkg;

    localparam int MAX_CITIES_DEF = 32;
    localparam int GENE_W         = 5;
    localparam int POS_W          = 5;
    localparam int NUM_GENES      = 32;

    typedef logic [GENE_W-1:0] gene_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEG,
        ST_FILL,
        ST_EMIT
    } state_t;

    // Child store control from the sequencer
    typedef struct packed {
        logic clear;
        logic wr;
    } child_ctl_t;

endpackage

// ----- design/ocx_if.sv -----
interface ocx_in_if;
    import ocx_pkg::*;

    logic  valid;
    logic  ready;
    gene_t gene_a;
    gene_t gene_b;
    gene_t cut_start;
    gene_t cut_end;
    logic  is_last;

    modport source (output valid, gene_a, gene_b, cut_start, cut_end, is_last, input ready);
    modport sink   (input valid, gene_a, gene_b, cut_start, cut_end, is_last, output ready);
endinterface

interface ocx_out_if;
    import ocx_pkg::*;

    logic  valid;
    logic  ready;
    logic  which_child;
    pos_t  position;
    gene_t city;
    logic  final_gene;

    modport source (output valid, which_child, position, city, final_gene, input ready);
    modport sink   (input valid, which_child, position, city, final_gene, output ready);
endinterface

// ----- design/ocx_parent_mem.sv -----
module ocx_parent_mem #(
    parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_CITIES)-1:0] wr_addr,
    input  ocx_pkg::gene_t                wr_gene_a,
    input  ocx_pkg::gene_t                wr_gene_b,
    input  logic [$clog2(MAX_CITIES)-1:0] rd_addr,
    input  logic                          rd_sel_b,
    output ocx_pkg::gene_t                rd_gene
);
    import ocx_pkg::*;

    gene_t store_a_reg [MAX_CITIES];
    gene_t store_b_reg [MAX_CITIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_a_reg[wr_addr] <= wr_gene_a;
            store_b_reg[wr_addr] <= wr_gene_b;
        end
    end

    assign rd_gene = rd_sel_b ? store_b_reg[rd_addr] : store_a_reg[rd_addr];

endmodule

// ----- design/ocx_child_mem.sv -----
module ocx_child_mem #(
    parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ocx_pkg::child_ctl_t           ctl,
    input  logic [$clog2(MAX_CITIES)-1:0] wr_addr,
    input  ocx_pkg::gene_t                wr_gene,
    input  logic [$clog2(MAX_CITIES)-1:0] rd_addr,
    output ocx_pkg::gene_t                rd_gene,
    input  ocx_pkg::gene_t                test_gene,
    output logic                          test_placed
);
    import ocx_pkg::*;

    gene_t                  child_reg [MAX_CITIES];
    logic [MAX_CITIES-1:0]  filled_reg;
    logic [MAX_CITIES-1:0]  filled_next;
    logic [NUM_GENES-1:0]   placed_reg;
    logic [NUM_GENES-1:0]   placed_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            child_reg[wr_addr] <= wr_gene;
        end
    end

    always_comb
    begin
        filled_next = filled_reg;
        placed_next = placed_reg;
        if (ctl.clear)
        begin
            filled_next = '0;
            placed_next = '0;
        end
        else if (ctl.wr)
        begin
            filled_next[wr_addr] = 1'b1;
            placed_next[wr_gene] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            placed_reg <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
            placed_reg <= placed_next;
        end
    end

    // unfilled positions read as city zero
    assign rd_gene     = filled_reg[rd_addr] ? child_reg[rd_addr] : '0;
    assign test_placed = placed_reg[test_gene];

endmodule

// ----- design/ocx_ctrl.sv -----
module ocx_ctrl #(
    parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ocx_in_if.sink                        din,
    ocx_out_if.source                     dout,
    output logic                          par_wr_en,
    output logic [$clog2(MAX_CITIES)-1:0] par_wr_addr,
    output logic [$clog2(MAX_CITIES)-1:0] par_rd_addr,
    output logic                          par_rd_sel_b,
    input  ocx_pkg::gene_t                par_rd_gene,
    output ocx_pkg::child_ctl_t           child_ctl,
    output logic [$clog2(MAX_CITIES)-1:0] child_wr_addr,
    output ocx_pkg::gene_t                child_wr_gene,
    output logic [$clog2(MAX_CITIES)-1:0] child_rd_addr,
    input  ocx_pkg::gene_t                child_rd_gene,
    output ocx_pkg::gene_t                child_test_gene,
    input  logic                          child_test_placed
);
    import ocx_pkg::*;

    localparam int IW = $clog2(MAX_CITIES);
    localparam int CW = $clog2(MAX_CITIES + 1);
    localparam int XW = (CW > GENE_W) ? CW : GENE_W;

    state_t        state_reg,  state_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] n_reg,      n_next;
    logic [IW-1:0] s_reg,      s_next;
    logic [IW-1:0] e_reg,      e_next;
    logic [IW-1:0] idx_reg,    idx_next;
    logic [IW-1:0] pos_reg,    pos_next;
    logic [IW-1:0] iter_reg,   iter_next;
    logic [CW-1:0] left_reg,   left_next;
    logic          child_reg,  child_next;
    logic          ov_reg,     ov_next;
    logic          oc_reg,     oc_next;
    pos_t          op_reg,     op_next;
    gene_t         og_reg,     og_next;
    logic          of_reg,     of_next;

    logic          accept;
    logic          full;
    logic [CW-1:0] n_new;
    logic [XW-1:0] n_m1;
    logic [XW-1:0] cs_sat;
    logic [XW-1:0] ce_sat;
    logic          take;
    logic          slot_free;
    logic          idx_wrap;
    logic          pos_wrap;
    logic          seg_last;
    logic          idx_last;
    logic          iter_last;

    assign din.ready = (state_reg == ST_LOAD);
    assign accept    = din.valid && din.ready;
    assign full      = (count_reg >= CW'(MAX_CITIES));
    assign n_new     = full ? count_reg : count_reg + CW'(1);
    assign n_m1      = XW'(n_new) - XW'(1);
    assign cs_sat    = (XW'(din.cut_start) > n_m1) ? n_m1 : XW'(din.cut_start);
    assign ce_sat    = (XW'(din.cut_end) > n_m1) ? n_m1 : XW'(din.cut_end);

    assign idx_wrap  = (CW'(idx_reg) + CW'(1) >= n_reg);
    assign pos_wrap  = (CW'(pos_reg) + CW'(1) >= n_reg);
    assign seg_last  = (idx_reg == e_reg);
    assign idx_last  = (CW'(idx_reg) + CW'(1) == n_reg);
    assign iter_last = (CW'(iter_reg) + CW'(1) == n_reg);
    assign take      = (left_reg != '0) && !child_test_placed;
    assign slot_free = !ov_reg || dout.ready;

    assign par_wr_en       = accept && !full;
    assign par_wr_addr     = count_reg[IW-1:0];
    assign par_rd_addr     = idx_reg;
    // own parent while copying the segment, the other one while filling
    assign par_rd_sel_b    = (state_reg == ST_FILL) ? !child_reg : child_reg;
    assign child_wr_addr   = (state_reg == ST_FILL) ? pos_reg : idx_reg;
    assign child_wr_gene   = par_rd_gene;
    assign child_rd_addr   = idx_reg;
    assign child_test_gene = par_rd_gene;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        iter_next       = iter_reg;
        left_next       = left_reg;
        child_next      = child_reg;
        ov_next         = ov_reg && !dout.ready;
        oc_next         = oc_reg;
        op_next         = op_reg;
        og_next         = og_reg;
        of_next         = of_reg;
        child_ctl.clear = 1'b0;
        child_ctl.wr    = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    count_next = n_new;
                    if (din.is_last)
                    begin
                        n_next          = n_new;
                        s_next          = (cs_sat > ce_sat) ? IW'(ce_sat) : IW'(cs_sat);
                        e_next          = (cs_sat > ce_sat) ? IW'(cs_sat) : IW'(ce_sat);
                        idx_next        = (cs_sat > ce_sat) ? IW'(ce_sat) : IW'(cs_sat);
                        count_next      = '0;
                        child_next      = 1'b0;
                        child_ctl.clear = 1'b1;
                        state_next      = ST_SEG;
                    end
                end
            end
            ST_SEG:
            begin
                child_ctl.wr = 1'b1;
                if (seg_last)
                begin
                    pos_next   = idx_wrap ? '0 : idx_reg + IW'(1);
                    idx_next   = idx_wrap ? '0 : idx_reg + IW'(1);
                    left_next  = n_reg - CW'(e_reg) + CW'(s_reg) - CW'(1);
                    iter_next  = '0;
                    state_next = ST_FILL;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_FILL:
            begin
                if (take)
                begin
                    child_ctl.wr = 1'b1;
                    pos_next     = pos_wrap ? '0 : pos_reg + IW'(1);
                    left_next    = left_reg - CW'(1);
                end
                idx_next  = idx_wrap ? '0 : idx_reg + IW'(1);
                iter_next = iter_reg + IW'(1);
                if (iter_last)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    oc_next = child_reg;
                    op_next = POS_W'(idx_reg);
                    og_next = child_rd_gene;
                    of_next = child_reg && idx_last;
                    if (idx_last)
                    begin
                        if (!child_reg)
                        begin
                            child_next      = 1'b1;
                            idx_next        = s_reg;
                            child_ctl.clear = 1'b1;
                            state_next      = ST_SEG;
                        end
                        else
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        iter_reg  <= iter_next;
        left_reg  <= left_next;
        child_reg <= child_next;
        oc_reg    <= oc_next;
        op_reg    <= op_next;
        og_reg    <= og_next;
        of_reg    <= of_next;
    end

    assign dout.valid       = ov_reg;
    assign dout.which_child = oc_reg;
    assign dout.position    = op_reg;
    assign dout.city        = og_reg;
    assign dout.final_gene  = of_reg;

endmodule

// ----- design/order_crossover_permutation.sv -----
// Sequence: load beats are taken while the sequencer is in its load state; after the
// last beat, each child runs a segment-copy pass, a fill pass and an emit pass in turn.
// Throughput: one load beat per cycle while din.ready is high; din.ready stays low from
// the last beat until the last gene of child two is issued, output stalls included.
// Reset: rst_n clears the sequencer, the load count, the output valid and the child
// fill/placed maps; the parent and child gene stores are undefined until written.
module order_crossover_permutation #(
    parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ocx_in_if.sink     din,
    ocx_out_if.source  dout
);
    import ocx_pkg::*;

    localparam int IW = $clog2(MAX_CITIES);

    // parent store port
    logic          par_wr_en;
    logic [IW-1:0] par_wr_addr;
    logic [IW-1:0] par_rd_addr;
    logic          par_rd_sel_b;
    gene_t         par_rd_gene;

    // child store port
    child_ctl_t    child_ctl;
    logic [IW-1:0] child_wr_addr;
    gene_t         child_wr_gene;
    logic [IW-1:0] child_rd_addr;
    gene_t         child_rd_gene;
    gene_t         child_test_gene;
    logic          child_test_placed;

    // Sequencer: load beats, then per child a segment copy, a cyclic fill pass that
    // tests each candidate gene against the placed map, and an emit pass.
    ocx_ctrl #(
        .MAX_CITIES (MAX_CITIES)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .din               (din),
        .dout              (dout),
        .par_wr_en         (par_wr_en),
        .par_wr_addr       (par_wr_addr),
        .par_rd_addr       (par_rd_addr),
        .par_rd_sel_b      (par_rd_sel_b),
        .par_rd_gene       (par_rd_gene),
        .child_ctl         (child_ctl),
        .child_wr_addr     (child_wr_addr),
        .child_wr_gene     (child_wr_gene),
        .child_rd_addr     (child_rd_addr),
        .child_rd_gene     (child_rd_gene),
        .child_test_gene   (child_test_gene),
        .child_test_placed (child_test_placed)
    );

    // Both parent tours, written together on each load beat while the store is not full
    ocx_parent_mem #(
        .MAX_CITIES (MAX_CITIES)
    ) u_parent_mem (
        .clk       (clk),
        .wr_en     (par_wr_en),
        .wr_addr   (par_wr_addr),
        .wr_gene_a (din.gene_a),
        .wr_gene_b (din.gene_b),
        .rd_addr   (par_rd_addr),
        .rd_sel_b  (par_rd_sel_b),
        .rd_gene   (par_rd_gene)
    );

    // Child under construction plus its placed-city map
    ocx_child_mem #(
        .MAX_CITIES (MAX_CITIES)
    ) u_child_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (child_ctl),
        .wr_addr     (child_wr_addr),
        .wr_gene     (child_wr_gene),
        .rd_addr     (child_rd_addr),
        .rd_gene     (child_rd_gene),
        .test_gene   (child_test_gene),
        .test_placed (child_test_placed)
    );

endmodule

// ----- design/ocx_checker.sv -----
`include "order_crossover_permutation_macros.svh"

module ocx_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 in_is_last,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 which_child,
    input ocx_pkg::pos_t        position,
    input ocx_pkg::gene_t       city,
    input logic                 final_gene
);
    import ocx_pkg::*;

    // a stalled result beat holds its payload
    `OCX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(city) && $stable(position) && $stable(which_child) && $stable(final_gene))

    // the final gene belongs to child two
    `OCX_ASSERT_NOW(a_final_child, out_valid && final_gene, which_child)

    // no load beat is taken while child one is still being emitted
    `OCX_ASSERT_NOW(a_busy_child_one, out_valid && !which_child, !in_ready)

    // the last beat starts the crossover and drops ready
    `OCX_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_is_last, !in_ready)

endmodule

bind order_crossover_permutation ocx_checker u_ocx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (din.valid),
    .in_ready    (din.ready),
    .in_is_last  (din.is_last),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .which_child (dout.which_child),
    .position    (dout.position),
    .city        (dout.city),
    .final_gene  (dout.final_gene)
);
